@@ sv/cesc_pkg.sv @@
// ----------------------------------------------------------------------------
// cesc_pkg
// Types, character codes and helpers for the C escape unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package cesc_pkg;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_OCT  = 2'd2
    } phase_t;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_V         = 8'h76;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;

    localparam logic [7:0] BY_BEL = 8'h07;
    localparam logic [7:0] BY_BS  = 8'h08;
    localparam logic [7:0] BY_FF  = 8'h0C;
    localparam logic [7:0] BY_LF  = 8'h0A;
    localparam logic [7:0] BY_CR  = 8'h0D;
    localparam logic [7:0] BY_HT  = 8'h09;
    localparam logic [7:0] BY_VT  = 8'h0B;

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_end;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       res0;
        res_t       res1;
    } step_t;

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_SEVEN);
    endfunction

    function automatic logic [7:0] escaped(input logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            CH_BACKSLASH: r = CH_BACKSLASH;
            CH_A:         r = BY_BEL;
            CH_B:         r = BY_BS;
            CH_F:         r = BY_FF;
            CH_N:         r = BY_LF;
            CH_R:         r = BY_CR;
            CH_T:         r = BY_HT;
            CH_V:         r = BY_VT;
            default:      r = b;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/cesc_if.sv @@
// ----------------------------------------------------------------------------
// cesc_in_if / cesc_out_if
// Valid/ready channels for escaped input bytes and unescaped result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface cesc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface cesc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_end;

    modport source (output valid, output out_byte, output is_end, input ready);
    modport sink   (input valid, input out_byte, input is_end, output ready);
endinterface

`default_nettype wire

@@ sv/cesc_step.sv @@
// ----------------------------------------------------------------------------
// cesc_step
// Escape state machine: holds phase and octal run, decodes one byte into
// zero, one or two results.
// ----------------------------------------------------------------------------
`default_nettype none

module cesc_step (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     in_byte,
    output cesc_pkg::step_t     step
);

    cesc_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       acc_reg, acc_next;
    logic [1:0]       dig_reg, dig_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cesc_pkg::PH_TEXT;
            acc_reg   <= '0;
            dig_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            dig_reg   <= dig_next;
        end
    end

    always_comb
    begin
        logic             oct;
        logic [7:0]       oct_acc;
        logic [1:0]       oct_dig;
        logic             p_emit;
        cesc_pkg::res_t   p_res;
        cesc_pkg::phase_t p_phase;

        oct     = cesc_pkg::is_octal(in_byte);
        oct_acc = {acc_reg[4:0], in_byte[2:0]};
        oct_dig = dig_reg + 2'd1;

        // byte taken as plain text
        p_emit  = 1'b1;
        p_res   = '{out_byte: in_byte, is_end: 1'b0};
        p_phase = cesc_pkg::PH_TEXT;
        if (in_byte == cesc_pkg::CH_NUL)
        begin
            p_res = '{out_byte: cesc_pkg::CH_NUL, is_end: 1'b1};
        end
        else if (in_byte == cesc_pkg::CH_BACKSLASH)
        begin
            p_emit  = 1'b0;
            p_phase = cesc_pkg::PH_ESC;
        end

        step       = '0;
        phase_next = cesc_pkg::PH_TEXT;
        acc_next   = '0;
        dig_next   = '0;

        unique case (phase_reg)
            cesc_pkg::PH_ESC:
            begin
                if (in_byte == cesc_pkg::CH_NUL)
                begin
                    step.count = 2'd1;
                    step.res0  = '{out_byte: cesc_pkg::CH_NUL, is_end: 1'b1};
                end
                else if (oct)
                begin
                    phase_next = cesc_pkg::PH_OCT;
                    acc_next   = {5'd0, in_byte[2:0]};
                    dig_next   = 2'd1;
                end
                else
                begin
                    step.count = 2'd1;
                    step.res0  = '{out_byte: cesc_pkg::escaped(in_byte), is_end: 1'b0};
                end
            end
            cesc_pkg::PH_OCT:
            begin
                if (oct)
                begin
                    if (oct_dig == 2'd3 || oct_dig == 2'd0)
                    begin
                        step.count = 2'd1;
                        step.res0  = '{out_byte: oct_acc, is_end: 1'b0};
                    end
                    else
                    begin
                        phase_next = cesc_pkg::PH_OCT;
                        acc_next   = oct_acc;
                        dig_next   = oct_dig;
                    end
                end
                else
                begin
                    step.count = p_emit ? 2'd2 : 2'd1;
                    step.res0  = '{out_byte: acc_reg, is_end: 1'b0};
                    step.res1  = p_res;
                    phase_next = p_phase;
                end
            end
            default:
            begin
                step.count = {1'b0, p_emit};
                step.res0  = p_res;
                phase_next = p_phase;
            end
        endcase
    end

    a_octal_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != cesc_pkg::PH_OCT |-> acc_reg == '0 && dig_reg == '0)
        else $error("octal state not cleared outside an octal run");

    a_octal_digits: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == cesc_pkg::PH_OCT |-> dig_reg == 2'd1 || dig_reg == 2'd2)
        else $error("octal run holds a bad digit count");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_byte == cesc_pkg::CH_NUL |=> phase_reg == cesc_pkg::PH_TEXT)
        else $error("terminator did not return to text");

endmodule

`default_nettype wire

@@ sv/c_escape_unescaper_unit.sv @@
// ----------------------------------------------------------------------------
// c_escape_unescaper_unit
// C string escape decoder, one escaped byte per request in.
// ----------------------------------------------------------------------------
// din carries the escaped string one byte per request; a zero byte ends it.
// dout carries unescaped bytes; the terminator is a zero byte with is_end set.
// Escapes: backslash with \ a b f n r t v, one to three octal digits, or any
// other byte that passes as itself. A request gives zero, one or two results.
// Decoding is done in the accepting cycle; results are registered in a
// four-entry result queue, and dout shows the queue's oldest result.
// Throughput: one request per cycle; din.ready is held low while the queue
// holds three or more results, since one request may add two. The queue
// drains one result per cycle while dout.ready is high; a second result
// from the same request waits in the queue directly behind the first.
// When dout stalls, the queue fills and din.ready drops; nothing is lost.
// Reset empties the queue and returns the decoder to plain text.
// ----------------------------------------------------------------------------
`default_nettype none

module c_escape_unescaper_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    cesc_in_if.sink      din,
    cesc_out_if.source   dout
);

    localparam int DEPTH = cesc_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    cesc_pkg::step_t step;
    cesc_pkg::res_t  mem_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          accept;
    logic          pop;
    logic [PW-1:0] wr_ptr_p1;

    assign din.ready = (cnt_reg <= CW'(DEPTH - 2));
    assign accept    = din.valid && din.ready;
    assign pop       = dout.valid && dout.ready;

    cesc_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (din.in_byte),
        .step    (step)
    );

    assign wr_ptr_p1 = wr_ptr_reg + PW'(1);

    always_comb
    begin
        logic [1:0] push;
        push        = accept ? step.count : 2'd0;
        wr_ptr_next = wr_ptr_reg + PW'(push);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        cnt_next    = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && step.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= step.res0;
        end
        if (accept && step.count == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= step.res1;
        end
    end

    assign dout.valid    = (cnt_reg != '0);
    assign dout.out_byte = mem_reg[rd_ptr_reg].out_byte;
    assign dout.is_end   = mem_reg[rd_ptr_reg].is_end;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != CW'(DEPTH) |-> PW'(wr_ptr_reg - rd_ptr_reg) == PW'(cnt_reg))
        else $error("queue pointers disagree with count");

    a_no_two_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> cnt_reg + CW'(step.count) <= CW'(DEPTH))
        else $error("request accepted without room for its results");

endmodule

`default_nettype wire

@@ sim/c_escape_unescaper_unit_tb.sv @@
// ----------------------------------------------------------------------------
// c_escape_unescaper_unit_tb
// Self-checking bench for the C escape decoder. Escaped strings go in as a
// byte stream with random gaps and stalls; a byte-level decoder model builds
// the expected results, and every accepted result is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module c_escape_unescaper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;

    cesc_in_if  din_if ();
    cesc_out_if dout_if ();

    c_escape_unescaper_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    logic [7:0]      pending_bytes[$];
    cesc_pkg::res_t  expected_results[$];

    // decoder model state
    cesc_pkg::phase_t dec_phase;
    logic [7:0]       oct_value;
    logic [1:0]       oct_count;

    int send_gap;
    int recv_gap;
    logic calm;
    logic sink_hold;
    logic hold_sender;

    int bytes_sent;
    int results_checked;
    int strings_ended;
    int err_count;

    logic [7:0] esc_letters[8] = '{cesc_pkg::CH_BACKSLASH, cesc_pkg::CH_A, cesc_pkg::CH_B,
                                   cesc_pkg::CH_F, cesc_pkg::CH_N, cesc_pkg::CH_R,
                                   cesc_pkg::CH_T, cesc_pkg::CH_V};

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------
    function void expect_result(input logic [7:0] b, input logic e);
        expected_results.push_back('{out_byte: b, is_end: e});
    endfunction

    function logic [7:0] unescape_char(input logic [7:0] b);
        unique case (b)
            cesc_pkg::CH_A:    return cesc_pkg::BY_BEL;
            cesc_pkg::CH_B:    return cesc_pkg::BY_BS;
            cesc_pkg::CH_F:    return cesc_pkg::BY_FF;
            cesc_pkg::CH_N:    return cesc_pkg::BY_LF;
            cesc_pkg::CH_R:    return cesc_pkg::BY_CR;
            cesc_pkg::CH_T:    return cesc_pkg::BY_HT;
            cesc_pkg::CH_V:    return cesc_pkg::BY_VT;
            default:           return b;
        endcase
    endfunction

    function logic octal_digit(input logic [7:0] b);
        return (b >= cesc_pkg::CH_ZERO) && (b <= cesc_pkg::CH_SEVEN);
    endfunction

    function void take_text(input logic [7:0] b);
        if (b == cesc_pkg::CH_NUL)
        begin
            expect_result(cesc_pkg::CH_NUL, 1'b1);
            dec_phase = cesc_pkg::PH_TEXT;
            oct_value = '0;
            oct_count = '0;
        end
        else if (b == cesc_pkg::CH_BACKSLASH)
        begin
            dec_phase = cesc_pkg::PH_ESC;
        end
        else
        begin
            expect_result(b, 1'b0);
            dec_phase = cesc_pkg::PH_TEXT;
        end
    endfunction

    function void decode_byte(input logic [7:0] b);
        unique case (dec_phase)
            cesc_pkg::PH_ESC:
            begin
                if (b == cesc_pkg::CH_NUL)
                begin
                    take_text(b);
                end
                else if (octal_digit(b))
                begin
                    oct_value = {5'b0, b[2:0]};
                    oct_count = 2'd1;
                    dec_phase = cesc_pkg::PH_OCT;
                end
                else
                begin
                    expect_result(unescape_char(b), 1'b0);
                    dec_phase = cesc_pkg::PH_TEXT;
                end
            end
            cesc_pkg::PH_OCT:
            begin
                if (octal_digit(b))
                begin
                    oct_value = {oct_value[4:0], b[2:0]};
                    oct_count = oct_count + 2'd1;
                    if (oct_count == 2'd3)
                    begin
                        expect_result(oct_value, 1'b0);
                        dec_phase = cesc_pkg::PH_TEXT;
                        oct_value = '0;
                        oct_count = '0;
                    end
                end
                else
                begin
                    // run cut short: flush its value, then treat byte as text
                    expect_result(oct_value, 1'b0);
                    oct_value = '0;
                    oct_count = '0;
                    dec_phase = cesc_pkg::PH_TEXT;
                    take_text(b);
                end
            end
            default:
            begin
                take_text(b);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function void queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back(s[i]);
    endfunction

    function void queue_token();
        int r;
        int n;
        logic [7:0] b;
        r = $urandom_range(99);
        if (r < 35)
        begin
            do
                b = 8'($urandom_range(1, 255));
            while (b == cesc_pkg::CH_BACKSLASH);
            pending_bytes.push_back(b);
        end
        else if (r < 55)
        begin
            pending_bytes.push_back(cesc_pkg::CH_BACKSLASH);
            pending_bytes.push_back(esc_letters[3'($urandom_range(7))]);
        end
        else if (r < 75)
        begin
            pending_bytes.push_back(cesc_pkg::CH_BACKSLASH);
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                pending_bytes.push_back(cesc_pkg::CH_ZERO + 8'($urandom_range(7)));
        end
        else if (r < 85)
        begin
            pending_bytes.push_back(cesc_pkg::CH_BACKSLASH);
            pending_bytes.push_back(8'($urandom_range(1, 255)));
        end
        else if (r < 92)
        begin
            pending_bytes.push_back(cesc_pkg::CH_NUL);
        end
        else
        begin
            pending_bytes.push_back(8'($urandom_range(255)));
        end
    endfunction

    function int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            din_if.valid   <= 1'b0;
            din_if.in_byte <= '0;
            send_gap       <= 0;
        end
        else
        begin
            if (din_if.valid && din_if.ready)
            begin
                decode_byte(din_if.in_byte);
                bytes_sent++;
            end
            if (!din_if.valid || din_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap     <= send_gap - 1;
                    din_if.valid <= 1'b0;
                end
                else if (hold_sender || pending_bytes.size() == 0)
                begin
                    din_if.valid <= 1'b0;
                end
                else
                begin
                    din_if.valid   <= 1'b1;
                    din_if.in_byte <= pending_bytes.pop_front();
                    send_gap       <= pick_gap();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_if.ready <= 1'b0;
            recv_gap      <= 0;
        end
        else
        begin
            if (dout_if.valid && dout_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: unexpected result out_byte=%02h is_end=%b",
                                 dout_if.out_byte, dout_if.is_end);
                end
                else
                begin
                    if (dout_if.out_byte !== expected_results[0].out_byte ||
                        dout_if.is_end !== expected_results[0].is_end)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("ERROR: result %0d exp %02h/%b, got %02h/%b",
                                     results_checked, expected_results[0].out_byte,
                                     expected_results[0].is_end, dout_if.out_byte,
                                     dout_if.is_end);
                    end
                    void'(expected_results.pop_front());
                end
                results_checked++;
                if (dout_if.is_end === 1'b1)
                    strings_ended++;
            end
            if (sink_hold)
            begin
                dout_if.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap      <= recv_gap - 1;
                dout_if.ready <= 1'b0;
            end
            else
            begin
                dout_if.ready <= 1'b1;
                recv_gap      <= pick_gap();
            end
        end
    end

    // stretches without idling on either side
    always @(negedge clk)
    begin
        if ($urandom_range(149) == 0)
            calm = !calm;
    end

    // long sink stall, then a sender pause until fully drained
    initial
    begin
        wait (bytes_sent >= 300);
        @(negedge clk);
        sink_hold = 1'b1;
        repeat (200) @(negedge clk);
        sink_hold = 1'b0;
        wait (bytes_sent >= 700);
        @(negedge clk);
        hold_sender = 1'b1;
        while (din_if.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
        hold_sender = 1'b0;
    end

    initial
    begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        din_if.valid    = 1'b0;
        din_if.in_byte  = '0;
        dout_if.ready   = 1'b0;
        calm            = 1'b0;
        sink_hold       = 1'b0;
        hold_sender     = 1'b0;
        bytes_sent      = 0;
        results_checked = 0;
        strings_ended   = 0;
        err_count       = 0;
        dec_phase       = cesc_pkg::PH_TEXT;
        oct_value       = '0;
        oct_count       = '0;

        // directed: escapes, extremes, octal overflow and cut-short runs
        queue_text("\\a\\n\\v\\\\");
        pending_bytes.push_back(8'hFF);
        queue_text("\\q\\777\\12\\t\\5");
        pending_bytes.push_back(cesc_pkg::CH_NUL);
        pending_bytes.push_back(cesc_pkg::CH_BACKSLASH);
        pending_bytes.push_back(cesc_pkg::CH_NUL);

        while (pending_bytes.size() < 1100)
            queue_token();
        pending_bytes.push_back(cesc_pkg::CH_NUL);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bytes.size() != 0 || din_if.valid || hold_sender)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Decoded %0d escaped bytes into %0d results across %0d strings,",
                 bytes_sent, results_checked, strings_ended);
        $display("with random gaps, a long output stall and a full drain pause.");
        if (err_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
